[design/vlac_pkg.sv]
package vlac_pkg;

   // Fixed sizes of the block
   localparam int MAX_CLASSES    = 64;
   localparam int COUNT_BITS     = 24;
   localparam int CLASS_BITS     = $clog2(MAX_CLASSES);
   localparam int NCLS_BITS      = $clog2(MAX_CLASSES + 1);
   localparam int SCORE_BITS     = 16;
   localparam int FRAC_BITS      = 16;
   localparam int ACC_BITS       = FRAC_BITS + 1;
   localparam int OUT_COUNT_BITS = 24;
   localparam int SUM_BITS       = COUNT_BITS + 1;
   localparam int REM_BITS       = SUM_BITS + 1;
   localparam int STEP_BITS      = $clog2(ACC_BITS + 1);

   // Configuration register widths
   localparam int NUM_CLASSES_BITS = 7;
   localparam int LABEL_BITS       = 6;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = NUM_CLASSES_BITS;

   localparam logic [NUM_CLASSES_BITS-1:0] NUM_CLASSES_RESET = NUM_CLASSES_BITS'(2);
   localparam logic [NCLS_BITS-1:0]        MIN_CLASSES       = NCLS_BITS'(2);

   // Truth score above 0.5 in Q8.8 marks a voxel as observed
   localparam logic signed [SCORE_BITS-1:0] OBSERVED_THRESHOLD = SCORE_BITS'(128);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NUM_CLASSES     = 2'd0,
      CSR_FREESPACE_LABEL = 2'd1,
      CSR_HAS_UNKNOWN     = 2'd2,
      CSR_UNKNOWN_LABEL   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      RATIO_FREE = 2'd0,
      RATIO_OCC  = 2'd1,
      RATIO_ALL  = 2'd2
   } ratio_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_LAUNCH  = 2'd1,
      ST_DIVIDE  = 2'd2,
      ST_RESPOND = 2'd3
   } state_type;

   // Commands from the controller to the datapath and divider
   typedef struct packed {
      logic      accept;
      logic      div_start;
      ratio_type sel;
      logic      store_q;
   } ctrl_cmd_type;

endpackage

[design/vlac_if.sv]
interface vlac_req_if;
   import vlac_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [SCORE_BITS-1:0] true_score;
   logic signed [SCORE_BITS-1:0] pred_score;
   logic                         last_voxel;

   modport source (output valid, true_score, pred_score, last_voxel, input ready);
   modport sink   (input valid, true_score, pred_score, last_voxel, output ready);
endinterface

interface vlac_rsp_if;
   import vlac_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [ACC_BITS-1:0]       free_acc;
   logic [ACC_BITS-1:0]       occ_acc;
   logic [ACC_BITS-1:0]       all_acc;
   logic [OUT_COUNT_BITS-1:0] freespace_total;
   logic [OUT_COUNT_BITS-1:0] freespace_correct;
   logic [OUT_COUNT_BITS-1:0] occupied_total;
   logic [OUT_COUNT_BITS-1:0] occupied_correct;

   modport source (output valid, free_acc, occ_acc, all_acc,
                   freespace_total, freespace_correct, occupied_total, occupied_correct,
                   input ready);
   modport sink   (input valid, free_acc, occ_acc, all_acc,
                   freespace_total, freespace_correct, occupied_total, occupied_correct,
                   output ready);
endinterface

[design/vlac_div.sv]
module vlac_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [vlac_pkg::SUM_BITS-1:0] num,
   input  logic [vlac_pkg::SUM_BITS-1:0] den,
   output logic                          done,
   output logic [vlac_pkg::ACC_BITS-1:0] quotient
);
   import vlac_pkg::*;

   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [SUM_BITS-1:0]  den_ff;
   logic [ACC_BITS-1:0]  quo_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 zero_ff;
   logic [REM_BITS-1:0]  shifted;
   logic                 bit_q;
   logic                 last_step;

   // First step compares the numerator itself: it never exceeds the denominator
   always_comb begin
      shifted   = (step_ff == '0) ? rem_ff : (rem_ff << 1);
      bit_q     = (shifted >= REM_BITS'(den_ff));
      rem_in    = bit_q ? (shifted - REM_BITS'(den_ff)) : shifted;
      last_step = (step_ff == STEP_BITS'(ACC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !start && busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_BITS'(1);
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= REM_BITS'(num);
         den_ff  <= den;
         quo_ff  <= '0;
         zero_ff <= (den == '0);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[ACC_BITS-2:0], bit_q};
      end
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : quo_ff;
endmodule

[design/vlac_ctrl.sv]
module vlac_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   input  logic                   rsp_ready,
   input  logic                   div_done,
   output logic                   req_ready,
   output logic                   rsp_valid,
   output vlac_pkg::ctrl_cmd_type cmd
);
   import vlac_pkg::*;

   state_type state_ff, state_in;
   ratio_type sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= RATIO_FREE;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd.div_start = 1'b0;
      cmd.store_q   = 1'b0;
      cmd.sel       = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_last) begin
               state_in = ST_LAUNCH;
               sel_in   = RATIO_FREE;
            end
         end
         ST_LAUNCH: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               cmd.store_q = 1'b1;
               unique case (sel_ff)
                  RATIO_FREE: begin
                     sel_in   = RATIO_OCC;
                     state_in = ST_LAUNCH;
                  end
                  RATIO_OCC: begin
                     sel_in   = RATIO_ALL;
                     state_in = ST_LAUNCH;
                  end
                  default: begin
                     state_in = ST_RESPOND;
                  end
               endcase
            end
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid && req_last) begin
                  state_in = ST_LAUNCH;
                  sel_in   = RATIO_FREE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
      cmd.accept = req_valid && req_ready;
   end
endmodule

[design/vlac_dp.sv]
module vlac_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vlac_pkg::ctrl_cmd_type               cmd,
   input  logic                                 csr_write_enable,
   input  logic [vlac_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [vlac_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic signed [vlac_pkg::SCORE_BITS-1:0] true_score,
   input  logic signed [vlac_pkg::SCORE_BITS-1:0] pred_score,
   input  logic                                 last_voxel,
   input  logic [vlac_pkg::ACC_BITS-1:0]        quotient,
   output logic [vlac_pkg::SUM_BITS-1:0]        div_num,
   output logic [vlac_pkg::SUM_BITS-1:0]        div_den,
   output logic [vlac_pkg::ACC_BITS-1:0]        free_acc,
   output logic [vlac_pkg::ACC_BITS-1:0]        occ_acc,
   output logic [vlac_pkg::ACC_BITS-1:0]        all_acc,
   output logic [vlac_pkg::OUT_COUNT_BITS-1:0]  freespace_total,
   output logic [vlac_pkg::OUT_COUNT_BITS-1:0]  freespace_correct,
   output logic [vlac_pkg::OUT_COUNT_BITS-1:0]  occupied_total,
   output logic [vlac_pkg::OUT_COUNT_BITS-1:0]  occupied_correct
);
   import vlac_pkg::*;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (c == '1) ? c : c + COUNT_BITS'(1);
   endfunction

   // Configuration
   logic [NUM_CLASSES_BITS-1:0] num_classes_ff;
   logic [LABEL_BITS-1:0]       free_label_ff;
   logic                        has_unknown_ff;
   logic [LABEL_BITS-1:0]       unk_label_ff;

   // Per-voxel argmax state
   logic [CLASS_BITS-1:0]        pos_ff, pos_in;
   logic signed [SCORE_BITS-1:0] tbest_ff, tbest_in, pbest_ff, pbest_in;
   logic [CLASS_BITS-1:0]        tclass_ff, tclass_in, pclass_ff, pclass_in;
   logic                         seen_ff, seen_in;

   // Running counts and the snapshot taken at set end
   logic [COUNT_BITS-1:0] ft_ff, ft_in, fc_ff, fc_in, ot_ff, ot_in, oc_ff, oc_in;
   logic [COUNT_BITS-1:0] ft_nx, fc_nx, ot_nx, oc_nx;
   logic [COUNT_BITS-1:0] s_ft_ff, s_fc_ff, s_ot_ff, s_oc_ff;
   logic [ACC_BITS-1:0]   q_free_ff, q_occ_ff, q_all_ff;

   logic [NCLS_BITS-1:0]  n_eff;
   logic [NCLS_BITS-1:0]  pos_wide;
   logic                  start_voxel, end_voxel, hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff <= NUM_CLASSES_RESET;
         free_label_ff  <= '0;
         has_unknown_ff <= 1'b0;
         unk_label_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_CLASSES:     num_classes_ff <= csr_write_data;
            CSR_FREESPACE_LABEL: free_label_ff  <= csr_write_data[LABEL_BITS-1:0];
            CSR_HAS_UNKNOWN:     has_unknown_ff <= csr_write_data[0];
            CSR_UNKNOWN_LABEL:   unk_label_ff   <= csr_write_data[LABEL_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      // Clamp the class count into its legal range
      if (num_classes_ff < NUM_CLASSES_BITS'(MIN_CLASSES)) begin
         n_eff = MIN_CLASSES;
      end else if (num_classes_ff > NUM_CLASSES_BITS'(MAX_CLASSES)) begin
         n_eff = NCLS_BITS'(MAX_CLASSES);
      end else begin
         n_eff = NCLS_BITS'(num_classes_ff);
      end
      pos_wide    = NCLS_BITS'(pos_ff);
      start_voxel = (pos_ff == '0) || (pos_wide >= n_eff);

      if (start_voxel) begin
         tbest_in  = true_score;
         tclass_in = '0;
         pbest_in  = pred_score;
         pclass_in = '0;
         seen_in   = 1'b0;
      end else begin
         tbest_in  = tbest_ff;
         tclass_in = tclass_ff;
         pbest_in  = pbest_ff;
         pclass_in = pclass_ff;
         seen_in   = seen_ff;
         if (true_score > tbest_ff) begin
            tbest_in  = true_score;
            tclass_in = pos_ff;
         end
         if (pred_score > pbest_ff) begin
            pbest_in  = pred_score;
            pclass_in = pos_ff;
         end
      end
      if (true_score > OBSERVED_THRESHOLD) begin
         seen_in = 1'b1;
      end

      end_voxel = (start_voxel ? (NCLS_BITS'(1) >= n_eff)
                               : (pos_wide + NCLS_BITS'(1) >= n_eff)) || last_voxel;
      pos_in    = end_voxel ? '0 : (start_voxel ? CLASS_BITS'(1) : pos_ff + CLASS_BITS'(1));
      hit       = (tclass_in == pclass_in);

      ft_nx = ft_ff;
      fc_nx = fc_ff;
      ot_nx = ot_ff;
      oc_nx = oc_ff;
      if (end_voxel) begin
         if (tclass_in == CLASS_BITS'(free_label_ff)) begin
            ft_nx = sat_inc(ft_ff);
            if (hit) fc_nx = sat_inc(fc_ff);
         end else if (seen_in &&
                      !(has_unknown_ff && (tclass_in == CLASS_BITS'(unk_label_ff)))) begin
            ot_nx = sat_inc(ot_ff);
            if (hit) oc_nx = sat_inc(oc_ff);
         end
      end

      ft_in = ft_ff;
      fc_in = fc_ff;
      ot_in = ot_ff;
      oc_in = oc_ff;
      if (cmd.accept) begin
         if (last_voxel) begin
            ft_in = '0;
            fc_in = '0;
            ot_in = '0;
            oc_in = '0;
         end else begin
            ft_in = ft_nx;
            fc_in = fc_nx;
            ot_in = ot_nx;
            oc_in = oc_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         tbest_ff  <= '0;
         tclass_ff <= '0;
         pbest_ff  <= '0;
         pclass_ff <= '0;
         seen_ff   <= 1'b0;
         ft_ff     <= '0;
         fc_ff     <= '0;
         ot_ff     <= '0;
         oc_ff     <= '0;
      end else begin
         if (cmd.accept) begin
            pos_ff    <= pos_in;
            tbest_ff  <= tbest_in;
            tclass_ff <= tclass_in;
            pbest_ff  <= pbest_in;
            pclass_ff <= pclass_in;
            seen_ff   <= seen_in;
         end
         ft_ff <= ft_in;
         fc_ff <= fc_in;
         ot_ff <= ot_in;
         oc_ff <= oc_in;
      end
   end

   // Snapshot and quotient registers hold the pending result
   always_ff @(posedge clock) begin
      if (cmd.accept && last_voxel) begin
         s_ft_ff <= ft_nx;
         s_fc_ff <= fc_nx;
         s_ot_ff <= ot_nx;
         s_oc_ff <= oc_nx;
      end
      if (cmd.store_q) begin
         unique case (cmd.sel)
            RATIO_FREE: q_free_ff <= quotient;
            RATIO_OCC:  q_occ_ff  <= quotient;
            default:    q_all_ff  <= quotient;
         endcase
      end
   end

   always_comb begin
      div_num = SUM_BITS'(s_fc_ff) + SUM_BITS'(s_oc_ff);
      div_den = SUM_BITS'(s_ft_ff) + SUM_BITS'(s_ot_ff);
      unique case (cmd.sel)
         RATIO_FREE: begin
            div_num = SUM_BITS'(s_fc_ff);
            div_den = SUM_BITS'(s_ft_ff);
         end
         RATIO_OCC: begin
            div_num = SUM_BITS'(s_oc_ff);
            div_den = SUM_BITS'(s_ot_ff);
         end
         default: begin
            div_num = SUM_BITS'(s_fc_ff) + SUM_BITS'(s_oc_ff);
            div_den = SUM_BITS'(s_ft_ff) + SUM_BITS'(s_ot_ff);
         end
      endcase
   end

   assign free_acc          = q_free_ff;
   assign occ_acc           = q_occ_ff;
   assign all_acc           = q_all_ff;
   assign freespace_total   = OUT_COUNT_BITS'(s_ft_ff);
   assign freespace_correct = OUT_COUNT_BITS'(s_fc_ff);
   assign occupied_total    = OUT_COUNT_BITS'(s_ot_ff);
   assign occupied_correct  = OUT_COUNT_BITS'(s_oc_ff);
endmodule

[design/voxel_label_accuracy_counter.sv]
// Voxel label accuracy counter. Class scores stream in one transaction per class,
// all classes of a voxel in a row; a running argmax of the truth and predicted
// scores is kept per voxel, and each finished voxel that is freespace, or observed
// and not unknown, bumps saturating freespace or occupied counts. An ordinary
// transaction is taken every cycle while the block is idle. The transaction that
// carries last_voxel closes the set: its counts are frozen, the running counts
// clear, and one shared restoring divider, one quotient bit per cycle, works out
// the three Q1.16 accuracies in turn (freespace, occupied, all). Input is held
// off from then on while the divisions run and while a result waits, except that
// a new transaction is taken in the cycle the waiting result is taken.
module voxel_label_accuracy_counter (
   input  logic                                clock,
   input  logic                                reset,
   vlac_req_if.sink                            req_if,
   vlac_rsp_if.source                          rsp_if,
   input  logic                                csr_write_enable,
   input  logic [vlac_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [vlac_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import vlac_pkg::*;

   ctrl_cmd_type        cmd;
   logic                div_done;
   logic [ACC_BITS-1:0] quotient;
   logic [SUM_BITS-1:0] div_num;
   logic [SUM_BITS-1:0] div_den;

   // Sequence the set-end division and the handshakes
   vlac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_voxel),
      .rsp_ready (rsp_if.ready),
      .div_done  (div_done),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .cmd       (cmd)
   );

   // Argmax, counts, configuration and result registers
   vlac_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .true_score        (req_if.true_score),
      .pred_score        (req_if.pred_score),
      .last_voxel        (req_if.last_voxel),
      .quotient          (quotient),
      .div_num           (div_num),
      .div_den           (div_den),
      .free_acc          (rsp_if.free_acc),
      .occ_acc           (rsp_if.occ_acc),
      .all_acc           (rsp_if.all_acc),
      .freespace_total   (rsp_if.freespace_total),
      .freespace_correct (rsp_if.freespace_correct),
      .occupied_total    (rsp_if.occupied_total),
      .occupied_correct  (rsp_if.occupied_correct)
   );

   // Shared divider: correct count shifted by 16 over total, zero on empty total
   vlac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (quotient)
   );
endmodule
